// ----- src/kst_pkg.sv -----
`default_nettype none

package kst_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 32;

    localparam int REQ_W    = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // request codes; the unused code falls through to a query
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

`default_nettype wire

// ----- src/kst_ram.sv -----
`default_nettype none

module kst_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/key_set_table.sv -----
`default_nettype none

// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  s_req_type, s_key
// m_        out        m_valid / m_ready  m_status, m_is_member, m_count
//
// Each request scans every slot, one per cycle through the memory read port,
// then passes S_LAST, which folds in the last slot read, S_WRITE, which writes
// back, and S_OUT, which loads the result into the m_ registers.
// After reset a clearing pass wipes every slot of the valid store;
// s_ready stays low meanwhile. A result waiting on m_ready holds the next
// request at its final step; a new request is taken while a result waits.
module key_set_table
    import kst_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [REQ_W-1:0]    s_req_type,
    input  wire logic [KEY_W-1:0]    s_key,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [STATUS_W-1:0] m_status,
    output logic                     m_is_member,
    output logic      [COUNT_W-1:0]  m_count
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_WRITE,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    scan_cnt_reg;
    logic                rd_vld_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic                free_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [CNT_W-1:0]    held_count_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic                m_is_member_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic [KEY_BITS-1:0] key_rd;
    logic [0:0]          valid_rd;

    logic                key_we;
    logic                valid_we;
    logic [IDX_W-1:0]    valid_waddr;
    logic [0:0]          valid_wdata;
    logic [STATUS_W-1:0] status_next;
    logic [CNT_W-1:0]    held_count_next;

    // decide the request outcome from the finished scan; drive the clearing writes in S_CLEAR
    always_comb begin
        key_we          = 1'b0;
        valid_we        = 1'b0;
        valid_waddr     = free_idx_reg;
        valid_wdata     = 1'b1;
        status_next     = ST_NOT_FOUND;
        held_count_next = held_count_reg;
        case (req_reg)
            REQ_INSERT: begin
                if (hit_reg) begin
                    status_next = ST_PRESENT;
                end else if (free_reg) begin
                    status_next     = ST_DONE;
                    key_we          = (state_reg == S_WRITE);
                    valid_we        = (state_reg == S_WRITE);
                    held_count_next = held_count_reg + CNT_W'(1);
                end else begin
                    status_next = ST_FULL;
                end
            end
            REQ_REMOVE: begin
                if (hit_reg) begin
                    status_next = ST_DONE;
                    valid_we    = (state_reg == S_WRITE);
                    valid_waddr = hit_idx_reg;
                    valid_wdata = 1'b0;
                    if (held_count_reg != '0) begin
                        held_count_next = held_count_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
                status_next = hit_reg ? ST_DONE : ST_NOT_FOUND;
            end
        endcase
        if (state_reg == S_CLEAR) begin
            valid_we    = 1'b1;
            valid_waddr = scan_cnt_reg;
            valid_wdata = 1'b0;
        end
    end

    kst_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (KEY_BITS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (free_idx_reg),
        .wdata (key_reg),
        .raddr (scan_cnt_reg),
        .rdata (key_rd)
    );

    kst_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (1)
    ) u_valid_ram (
        .aclk  (aclk),
        .we    (valid_we),
        .waddr (valid_waddr),
        .wdata (valid_wdata),
        .raddr (scan_cnt_reg),
        .rdata (valid_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            scan_cnt_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            held_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // drop the word once taken; S_OUT reloads it on its own
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end

            // fold in the slot read issued in the previous cycle; keep the first free slot
            if (rd_vld_reg) begin
                if (valid_rd[0] && key_rd == key_reg) begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_idx_reg;
                end
                if (!valid_rd[0] && !free_reg) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
            end

            case (state_reg)
                S_CLEAR: begin
                    if (scan_cnt_reg == LAST_IDX) begin
                        scan_cnt_reg <= '0;
                        state_reg    <= S_IDLE;
                    end else begin
                        scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg      <= s_req_type;
                        key_reg      <= KEY_BITS'(s_key);
                        hit_reg      <= 1'b0;
                        free_reg     <= 1'b0;
                        scan_cnt_reg <= '0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    rd_vld_reg   <= 1'b1;
                    rd_idx_reg   <= scan_cnt_reg;
                    if (scan_cnt_reg == LAST_IDX) begin
                        scan_cnt_reg <= '0;
                        state_reg    <= S_LAST;
                    end else begin
                        scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                    end
                end
                S_LAST: begin
                    rd_vld_reg <= 1'b0;
                    state_reg  <= S_WRITE;
                end
                S_WRITE: begin
                    res_status_reg <= status_next;
                    held_count_reg <= held_count_next;
                    state_reg      <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg     <= 1'b1;
                        m_status_reg    <= res_status_reg;
                        m_is_member_reg <= hit_reg;
                        m_count_reg     <= COUNT_W'(held_count_reg);
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_is_member = m_is_member_reg;
    assign m_count     = m_count_reg;

endmodule

`default_nettype wire
